@@ sv/lnor_pkg.sv @@
package lnor_pkg;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RANGE_W-1:0] RANGE_MISSING = 16'hFFFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_OUTER = 3'd0,
    REG_RADIUS_INNER = 3'd1,
    REG_GAIN_TRACK   = 3'd2,
    REG_GAIN_OUTER   = 3'd3,
    REG_GAIN_INNER   = 3'd4,
    REG_LIMIT_TRACK  = 3'd5,
    REG_LIMIT_AVOID  = 3'd6,
    REG_LIMIT_TOTAL  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_DY,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_XL,
    ST_XH,
    ST_YL,
    ST_YH,
    ST_YA,
    ST_RND,
    ST_SUM
  } state_t;

  // sine in Q14, one entry per degree over the first quadrant
  localparam logic [14:0] SIN_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // a below 450 degrees
  function automatic logic signed [15:0] sin_deg(input logic [9:0] a);
    logic [9:0] m;
    logic [9:0] k;
    logic       neg;
    logic [15:0] mag;
    m = (a >= 10'd360) ? (a - 10'd360) : a;
    if (m <= 10'd90) begin
      k = m;
      neg = 1'b0;
    end else if (m <= 10'd180) begin
      k = 10'd180 - m;
      neg = 1'b0;
    end else if (m <= 10'd270) begin
      k = m - 10'd180;
      neg = 1'b1;
    end else begin
      k = 10'd360 - m;
      neg = 1'b1;
    end
    mag = {1'b0, SIN_Q14[k[6:0]]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat26(input logic signed [25:0] v,
                                               input logic [LIMIT_W-1:0] lim);
    logic signed [25:0] l;
    l = $signed({11'd0, lim});
    if (v > l) begin
      return l[15:0];
    end else if (v < -l) begin
      return 16'(-l);
    end
    return v[15:0];
  endfunction

endpackage

@@ sv/lidar_nearest_obstacle_repulsion.sv @@
// Channel  | Ports                                   | Beat
// ---------+-----------------------------------------+--------------------------------
// in       | in_valid/in_ready, in_* fields          | one range sample or control tick
// out      | out_valid/out_ready, out_* fields       | one velocity command per tick
// cfg      | cfg_we, cfg_index, cfg_wdata            | one register write per cycle
//
// A range sample is registered on the edge that accepts it; in_ready stays high for back to back samples.
// A tick steps the sequencer through its states: the single 18x18 multiplier is used eight times in turn
// (tracking x/y, the two force terms, force times cos and sin in two halves each).
// The tick result sits in the output register; a stalled result holds the sequencer in
// its last state but samples keep flowing once it is back in idle.
// rst_n is synchronous: registers return to their reset values, no item is held.
module lidar_nearest_obstacle_repulsion
  import lnor_pkg::*;
#(
  parameter int unsigned SCAN_POINTS  = 360,
  parameter int unsigned WINDOW_FIRST = 0,
  parameter int unsigned WINDOW_LAST  = 359
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [15:0]          in_range_mm,
  input  logic                 in_scan_end,
  input  logic signed [15:0]   in_pos_x,
  input  logic signed [15:0]   in_pos_y,
  input  logic signed [15:0]   in_goal_x,
  input  logic signed [15:0]   in_goal_y,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_vel_x,
  output logic signed [15:0]   out_vel_y,
  output logic                 out_avoid_active,
  output logic [15:0]          out_nearest_range_out,
  output logic [8:0]           out_nearest_angle_out,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam logic [ANGLE_W-1:0] LAST_IDX = ANGLE_W'(SCAN_POINTS - 1);
  localparam logic [ANGLE_W-1:0] WIN_FIRST = ANGLE_W'(WINDOW_FIRST);
  localparam logic [ANGLE_W-1:0] WIN_LAST = ANGLE_W'(WINDOW_LAST);

  localparam logic signed [35:0] TRK_HALF = 36'sd2048;
  localparam logic signed [49:0] AVD_HALF = 50'sd33554432;

  // configuration
  logic [15:0]        radius_outer_r, radius_inner_r;
  logic [15:0]        gain_track_r, gain_outer_r, gain_inner_r;
  logic [LIMIT_W-1:0] limit_track_r, limit_avoid_r, limit_total_r;

  // scan state
  logic [ANGLE_W-1:0] idx_r;
  logic [RANGE_W-1:0] prev_r;
  logic               lead_miss_r;
  logic               lw_valid_r;
  logic [ANGLE_W-1:0] lw_angle_r;
  logic [RANGE_W-1:0] rmin_r;
  logic [ANGLE_W-1:0] rang_r;
  logic [RANGE_W-1:0] nearest_range_r;
  logic [ANGLE_W-1:0] nearest_angle_r;

  // tick datapath
  state_t             state_r, state_nxt;
  logic signed [16:0] dx_r, dy_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [35:0] p_r;
  logic signed [33:0] f_r;
  logic signed [49:0] acc_r;
  logic signed [15:0] tx_r, ty_r, ax_r, ay_r;
  logic signed [17:0] mul_a, mul_b;

  logic               out_valid_r;
  logic signed [15:0] out_vel_x_r, out_vel_y_r;
  logic               out_avoid_active_r;
  logic [RANGE_W-1:0] out_nearest_range_r;
  logic [ANGLE_W-1:0] out_nearest_angle_r;

  logic in_acc, sample_acc, tick_acc, out_load;

  assign in_acc     = in_valid && in_ready;
  assign sample_acc = in_acc && (opcode_t'(in_opcode) == OP_SAMPLE);
  assign tick_acc   = in_acc && (opcode_t'(in_opcode) == OP_TICK);
  assign out_load   = (state_r == ST_SUM) && (!out_valid_r || out_ready);

  // ---------------- sample path ----------------
  logic               rng_missing, in_win, resolved, take_min, scan_done, use_lead;
  logic               lw_valid_upd;
  logic [ANGLE_W-1:0] lw_angle_upd, rang_upd, na;
  logic [RANGE_W-1:0] val, rmin_upd, nr;

  always_comb begin
    rng_missing  = (in_range_mm == RANGE_MISSING);
    in_win       = (idx_r == WIN_FIRST) || ((idx_r >= WIN_FIRST) && (idx_r <= WIN_LAST));
    resolved     = !(rng_missing && lead_miss_r);
    val          = rng_missing ? prev_r : in_range_mm;
    lw_valid_upd = lw_valid_r || (rng_missing && lead_miss_r && in_win);
    lw_angle_upd = (!lw_valid_r && rng_missing && lead_miss_r && in_win) ? idx_r : lw_angle_r;
    take_min     = resolved && in_win && (val < rmin_r);
    rmin_upd     = take_min ? val : rmin_r;
    rang_upd     = take_min ? idx_r : rang_r;
    scan_done    = in_scan_end || (idx_r >= LAST_IDX);
    // leading gap is filled with the closing raw value
    use_lead     = lw_valid_upd && (in_range_mm <= rmin_upd);
    nr           = use_lead ? in_range_mm : rmin_upd;
    na           = use_lead ? lw_angle_upd : rang_upd;
    if (nr == RANGE_MISSING) begin
      na = WIN_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r           <= '0;
      prev_r          <= RANGE_MISSING;
      lead_miss_r     <= 1'b1;
      lw_valid_r      <= 1'b0;
      lw_angle_r      <= '0;
      rmin_r          <= RANGE_MISSING;
      rang_r          <= '0;
      nearest_range_r <= RANGE_MISSING;
      nearest_angle_r <= '0;
    end else if (sample_acc) begin
      if (scan_done) begin
        idx_r           <= '0;
        prev_r          <= RANGE_MISSING;
        lead_miss_r     <= 1'b1;
        lw_valid_r      <= 1'b0;
        lw_angle_r      <= '0;
        rmin_r          <= RANGE_MISSING;
        rang_r          <= '0;
        nearest_range_r <= nr;
        nearest_angle_r <= na;
      end else begin
        idx_r      <= idx_r + 1'b1;
        lw_valid_r <= lw_valid_upd;
        lw_angle_r <= lw_angle_upd;
        rmin_r     <= rmin_upd;
        rang_r     <= rang_upd;
        if (resolved) begin
          prev_r <= val;
        end
        if (!rng_missing) begin
          lead_miss_r <= 1'b0;
        end
      end
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_outer_r <= 16'd2000;
      radius_inner_r <= 16'd1000;
      gain_track_r   <= 16'd2048;
      gain_outer_r   <= '0;
      gain_inner_r   <= '0;
      limit_track_r  <= 15'd500;
      limit_avoid_r  <= '0;
      limit_total_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS_OUTER: radius_outer_r <= cfg_wdata;
        REG_RADIUS_INNER: radius_inner_r <= cfg_wdata;
        REG_GAIN_TRACK:   gain_track_r   <= cfg_wdata;
        REG_GAIN_OUTER:   gain_outer_r   <= cfg_wdata;
        REG_GAIN_INNER:   gain_inner_r   <= cfg_wdata;
        REG_LIMIT_TRACK:  limit_track_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_LIMIT_AVOID:  limit_avoid_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_LIMIT_TOTAL:  limit_total_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- tick sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (tick_acc) state_nxt = ST_DX;
      ST_DX:   state_nxt = ST_DY;
      ST_DY:   state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_XL;
      ST_XL:   state_nxt = ST_XH;
      ST_XH:   state_nxt = ST_YL;
      ST_YL:   state_nxt = ST_YH;
      ST_YH:   state_nxt = ST_YA;
      ST_YA:   state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SUM;
      ST_SUM:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic               d_gt_ri;
  logic signed [17:0] f_lo, f_hi;

  assign d_gt_ri = nearest_range_r > radius_inner_r;
  assign f_lo    = $signed({1'b0, f_r[16:0]});
  assign f_hi    = $signed({f_r[33], f_r[33:17]});

  // multiplier operand select
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_DX: begin
        mul_a = 18'(dx_r);
        mul_b = $signed({2'b0, gain_track_r});
      end
      ST_DY: begin
        mul_a = 18'(dy_r);
        mul_b = $signed({2'b0, gain_track_r});
      end
      ST_F1: begin
        mul_a = $signed({2'b0, gain_outer_r});
        mul_b = d_gt_ri ? ($signed({2'b0, radius_outer_r}) - $signed({2'b0, nearest_range_r}))
                        : ($signed({2'b0, radius_outer_r}) - $signed({2'b0, radius_inner_r}));
      end
      ST_F2: begin
        mul_a = $signed({2'b0, gain_inner_r});
        mul_b = d_gt_ri ? 18'sd0
                        : ($signed({2'b0, radius_inner_r}) - $signed({2'b0, nearest_range_r}));
      end
      ST_XL: begin
        mul_a = f_lo;
        mul_b = 18'(cos_r);
      end
      ST_XH: begin
        mul_a = f_hi;
        mul_b = 18'(cos_r);
      end
      ST_YL: begin
        mul_a = f_lo;
        mul_b = 18'(sin_r);
      end
      ST_YH: begin
        mul_a = f_hi;
        mul_b = 18'(sin_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // rounding to nearest, ties away from zero
  logic signed [35:0] trk_sum;
  logic signed [49:0] avd_sum, acc_hi;
  logic signed [25:0] trk_rnd, avd_rnd;
  logic               active;
  logic signed [25:0] sum_x, sum_y;

  always_comb begin
    trk_sum = p_r + (p_r[35] ? (TRK_HALF - 36'sd1) : TRK_HALF);
    trk_rnd = 26'(trk_sum >>> 12);
    avd_sum = acc_r + (acc_r[49] ? (AVD_HALF - 50'sd1) : AVD_HALF);
    avd_rnd = -26'(avd_sum >>> 26);
    acc_hi  = 50'(p_r) <<< 17;
    active  = nearest_range_r < radius_outer_r;
    sum_x   = 26'(tx_r) + (active ? 26'(ax_r) : 26'sd0);
    sum_y   = 26'(ty_r) + (active ? 26'(ay_r) : 26'sd0);
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (tick_acc) begin
      dx_r <= 17'(in_goal_x) - 17'(in_pos_x);
      dy_r <= 17'(in_goal_y) - 17'(in_pos_y);
    end
    case (state_r)
      ST_DX: begin
        cos_r <= sin_deg({1'b0, nearest_angle_r} + 10'd90);
        sin_r <= sin_deg({1'b0, nearest_angle_r});
      end
      ST_DY:  tx_r  <= sat26(trk_rnd, limit_track_r);
      ST_F1:  ty_r  <= sat26(trk_rnd, limit_track_r);
      ST_F2:  f_r   <= p_r[33:0];
      ST_F3:  f_r   <= f_r + p_r[33:0];
      ST_XH:  acc_r <= 50'(p_r);
      ST_YL:  acc_r <= acc_r + acc_hi;
      ST_YH: begin
        ax_r  <= sat26(avd_rnd, limit_avoid_r);
        acc_r <= 50'(p_r);
      end
      ST_YA:  acc_r <= acc_r + acc_hi;
      ST_RND: ay_r  <= sat26(avd_rnd, limit_avoid_r);
      default: ;
    endcase
    if (out_load) begin
      out_vel_x_r         <= sat26(sum_x, limit_total_r);
      out_vel_y_r         <= sat26(sum_y, limit_total_r);
      out_avoid_active_r  <= active;
      out_nearest_range_r <= nearest_range_r;
      out_nearest_angle_r <= nearest_angle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_vel_x             = out_vel_x_r;
  assign out_vel_y             = out_vel_y_r;
  assign out_avoid_active      = out_avoid_active_r;
  assign out_nearest_range_out = out_nearest_range_r;
  assign out_nearest_angle_out = out_nearest_angle_r;

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("scan index past last sample");

  a_load_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_SUM)
    else $error("result raised outside the final step");

  a_avoid_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_avoid_active_r) |-> out_nearest_range_r < radius_outer_r)
    else $error("avoidance flagged outside outer radius");

  a_vel_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_vel_x_r <= $signed({1'b0, limit_total_r}))
                 && (out_vel_x_r >= -$signed({1'b0, limit_total_r})))
    else $error("x velocity beyond total limit");
`endif

endmodule
